@@ rtl/core/fmd_pkg.sv @@
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared types and constants of the fetal movement detector.
// ----------------------------------------------------------------------------
package fmd_pkg;

	localparam logic [7:0]  RATE_MIN    = 8'd60;
	localparam logic [7:0]  RATE_MAX    = 8'd210;
	localparam logic [7:0]  BASE_MIN    = 8'd100;
	localparam logic [8:0]  ACCEL_STEP  = 9'd8;
	localparam logic [15:0] HIT_SUM     = 16'd740;
	localparam int          SCORE_SHIFT = 6;
	localparam logic [5:0]  SCORE_MOD   = 6'd40;
	localparam logic [6:0]  COUNT_MAX   = 7'd99;
	localparam logic [7:0]  MAN_START   = 8'd5;
	localparam logic [7:0]  AUTO_START  = 8'd10;
	localparam int          PRESS_DEPTH = 16;
	localparam logic signed [7:0] PRESS_BASE = 8'sd20;
	localparam logic signed [8:0] PRESS_RISE = 9'sd12;

	localparam logic [1:0] CFG_CHANNEL = 2'd0;
	localparam logic [1:0] CFG_COUNT   = 2'd1;
	localparam logic [1:0] CFG_DEMO    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAN,
		ST_UPD,
		ST_START,
		ST_SCAN,
		ST_PRS,
		ST_FIN,
		ST_DONE
	} fmd_state_t;

	typedef struct packed {
		logic clr;
		logic wr;
		logic start;
		logic chan;
	} fmd_win_ctl_t;

endpackage

@@ rtl/core/fmd_rate_scan.sv @@
// ----------------------------------------------------------------------------
// fmd_rate_scan
// Heart-rate window memory and the sequential acceleration scan.
// ----------------------------------------------------------------------------
module fmd_rate_scan import fmd_pkg::*; #(
	parameter int RATE_WINDOW = 50
) (
	input  logic         clk,
	input  logic         arst_n,
	input  fmd_win_ctl_t ctl,
	input  logic [7:0]   rate_one,
	input  logic [7:0]   rate_two,
	output logic         done,
	output logic [5:0]   score,
	output logic         hit
);

	localparam int AW = $clog2(RATE_WINDOW);
	localparam int CW = AW + 1;
	localparam int SW = $clog2(7 * RATE_WINDOW + 1);

	logic [15:0]            mem [RATE_WINDOW];
	logic [RATE_WINDOW-1:0] vld_q;
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          ref_addr;
	logic [AW-1:0]          rd_addr;
	logic [CW-1:0]          idx_q;
	logic                   busy_q;
	logic                   done_q;
	logic                   base_s1;
	logic                   data_s1;
	logic                   rvld_s1;
	logic [15:0]            row_s1;
	logic [7:0]             base_q;
	logic [SW-1:0]          sum_q;
	logic [7:0]             rdv;
	logic [8:0]             diff;
	logic                   take;
	logic                   issue;
	logic [5:0]             sh;

	assign ref_addr = (wp_q == AW'(RATE_WINDOW - 1)) ? '0 : wp_q + 1'b1;
	assign issue    = busy_q && (idx_q != CW'(RATE_WINDOW));
	assign rd_addr  = ctl.start ? ref_addr : idx_q[AW-1:0];
	assign rdv      = rvld_s1 ? (ctl.chan ? row_s1[15:8] : row_s1[7:0]) : 8'd0;
	assign diff     = {1'b0, rdv} - {1'b0, base_q};
	assign take     = (base_q > BASE_MIN) && (rdv > base_q) && (diff < ACCEL_STEP);

	always_ff @(posedge clk) begin
		if (ctl.wr)
			mem[wp_q] <= {rate_two, rate_one};
		row_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			wp_q    <= '0;
			rvld_s1 <= 1'b0;
			base_s1 <= 1'b0;
			data_s1 <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
			base_q  <= '0;
			sum_q   <= '0;
		end else begin
			done_q  <= 1'b0;
			rvld_s1 <= vld_q[rd_addr];
			base_s1 <= ctl.start;
			data_s1 <= issue;
			if (ctl.clr) begin
				vld_q <= '0;
				wp_q  <= '0;
			end else if (ctl.wr) begin
				vld_q[wp_q] <= 1'b1;
				wp_q <= (wp_q == AW'(RATE_WINDOW - 1)) ? '0 : wp_q + 1'b1;
			end
			if (ctl.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				sum_q  <= '0;
			end else if (busy_q) begin
				if (issue)
					idx_q <= idx_q + 1'b1;
				if (base_s1)
					base_q <= rdv;
				if (data_s1 && take)
					sum_q <= sum_q + SW'(diff[2:0]);
				if (!issue && !data_s1 && !base_s1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sh    = 6'(sum_q >> SCORE_SHIFT);
	assign score = (sh >= SCORE_MOD) ? sh - SCORE_MOD : sh;
	assign hit   = 16'(sum_q) > HIT_SUM;
	assign done  = done_q;

endmodule

@@ rtl/core/fmd_press_chk.sv @@
// ----------------------------------------------------------------------------
// fmd_press_chk
// Pressure history line and spike detection over its taps.
// ----------------------------------------------------------------------------
module fmd_press_chk import fmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fmd_win_ctl_t      ctl,
	input  logic signed [7:0] pressure,
	output logic              spike
);

	logic signed [7:0] sr_q [PRESS_DEPTH];
	logic signed [8:0] dif;
	logic              any;

	// sr_q[0] newest; scan position m maps to sr_q[(14 - m) mod 16]
	// the slot at the write position sits in sr_q[15]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PRESS_DEPTH; k++)
				sr_q[k] <= (k == PRESS_DEPTH - 1) ? -8'sd1 : 8'sd0;
		end else if (ctl.clr) begin
			for (int k = 0; k < PRESS_DEPTH; k++)
				sr_q[k] <= 8'sd0;
		end else if (ctl.wr) begin
			sr_q[0] <= pressure;
			for (int k = 1; k < PRESS_DEPTH; k++)
				sr_q[k] <= sr_q[k-1];
		end
	end

	always_comb begin
		any = 1'b0;
		dif = '0;
		for (int i = 3; i < 14; i++) begin
			dif = {sr_q[4'(14 - i)][7], sr_q[4'(14 - i)]}
				- {sr_q[4'(12 - i)][7], sr_q[4'(12 - i)]};
			if (dif > 9'(20 - i))
				any = 1'b1;
		end
	end

	assign spike = (sr_q[14] > PRESS_BASE)
		&& ($signed({sr_q[11][7], sr_q[11]} - {sr_q[14][7], sr_q[14]}) > PRESS_RISE)
		&& any;

endmodule

@@ rtl/core/fetal_movement_detector_core.sv @@
// ----------------------------------------------------------------------------
// fetal_movement_detector_core
// Movement counting from heart-rate accelerations, pressure spikes and
// manual marks.
// ----------------------------------------------------------------------------
// A sample on the automatic path holds in_stall high while the heart-rate
// window is scanned, one entry per cycle through a single registered memory
// port; a new request is taken only once the core is back in ST_IDLE. A sample
// whose rate level falls to zero or below skips the scan, and demo and
// manual-only samples go from ST_MAN straight to ST_DONE. The result sits in an
// output register so the next sample can enter; while that register is full
// and stalled, in_stall stays high.
module fetal_movement_detector_core import fmd_pkg::*; #(
	parameter int RATE_WINDOW   = 50,
	parameter int HOLDOFF_LIMIT = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rate_one,
	input  logic [7:0]        rate_two,
	input  logic signed [7:0] pressure,
	input  logic              manual_press,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [6:0]        movement_count,
	output logic [5:0]        auto_score,
	output logic              manual_event,
	output logic              auto_event,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic              cfg_data
);

	localparam logic [7:0] HOLD_LIM  = 8'(HOLDOFF_LIMIT);
	localparam logic [7:0] HOLD_NEAR = 8'(HOLDOFF_LIMIT - 3);

	fmd_state_t        state_q, state_nxt;
	fmd_win_ctl_t      ctl;
	logic              chan_q, cmode_q, demo_q;
	logic [7:0]        r1_q, r2_q;
	logic signed [7:0] pr_q;
	logic              press_q;
	logic [7:0]        mh_q, ah_q, mh_dec, ah_dec;
	logic [6:0]        count_q, count_inc;
	logic [5:0]        score_q;
	logic signed [2:0] lvl_q, lvl_nxt;
	logic              man_ev_q, auto_ev_q, hit_q;
	logic              out_valid_q;
	logic [6:0]        out_count_q;
	logic [5:0]        out_score_q;
	logic              out_man_q, out_auto_q;
	logic              load_out;
	logic              accept;
	logic [7:0]        sel;
	logic              scan_done, scan_hit, spike;
	logic [5:0]        scan_score;

	fmd_rate_scan #(.RATE_WINDOW(RATE_WINDOW)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rate_one (r1_q),
		.rate_two (r2_q),
		.done     (scan_done),
		.score    (scan_score),
		.hit      (scan_hit)
	);

	fmd_press_chk u_press (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pressure (pr_q),
		.spike    (spike)
	);

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign mh_dec    = (mh_q != 8'd0) ? mh_q - 8'd1 : 8'd0;
	assign ah_dec    = (ah_q != 8'd0) ? ah_q - 8'd1 : 8'd0;
	assign count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 7'd1;
	assign sel       = chan_q ? r2_q : r1_q;
	assign lvl_nxt   = ((sel < RATE_MIN) || (sel > RATE_MAX)) ? lvl_q - 3'sd1 : 3'sd2;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_MAN;
			ST_MAN:   state_nxt = (demo_q || cmode_q) ? ST_DONE : ST_UPD;
			ST_UPD:   state_nxt = (lvl_nxt > 3'sd0) ? ST_START : ST_FIN;
			ST_START: state_nxt = ST_SCAN;
			ST_SCAN:  if (scan_done) state_nxt = ST_PRS;
			ST_PRS:   state_nxt = ST_FIN;
			ST_FIN:   state_nxt = ST_DONE;
			ST_DONE:  if (load_out) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.chan  = chan_q;
		ctl.clr   = (state_q == ST_UPD) && (lvl_nxt == 3'sd0);
		ctl.wr    = (state_q == ST_UPD) && (lvl_nxt > 3'sd0);
		ctl.start = (state_q == ST_START);
		load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			r1_q    <= rate_one;
			r2_q    <= rate_two;
			pr_q    <= pressure;
			press_q <= manual_press;
		end
		if (load_out) begin
			out_count_q <= count_q;
			out_score_q <= score_q;
			out_man_q   <= man_ev_q;
			out_auto_q  <= auto_ev_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_q      <= 1'b0;
			cmode_q     <= 1'b0;
			demo_q      <= 1'b0;
			mh_q        <= MAN_START;
			ah_q        <= AUTO_START;
			count_q     <= '0;
			score_q     <= '0;
			lvl_q       <= 3'sd3;
			man_ev_q    <= 1'b0;
			auto_ev_q   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_CHANNEL: chan_q  <= cfg_data;
					CFG_COUNT:   cmode_q <= cfg_data;
					CFG_DEMO:    demo_q  <= cfg_data;
					default: ;
				endcase
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_MAN: begin
					man_ev_q  <= 1'b0;
					auto_ev_q <= 1'b0;
					if (demo_q) begin
						mh_q <= MAN_START;
						ah_q <= AUTO_START;
					end else if (mh_dec == 8'd0) begin
						if (press_q) begin
							mh_q     <= HOLD_LIM;
							man_ev_q <= 1'b1;
							if (cmode_q || ah_q == 8'd0)
								count_q <= count_inc;
						end else begin
							mh_q <= mh_dec;
						end
					end else if (press_q && mh_dec > HOLD_NEAR) begin
						mh_q <= HOLD_LIM;
					end else begin
						mh_q <= mh_dec;
					end
				end
				ST_UPD: begin
					ah_q <= ah_dec;
					if (lvl_nxt > 3'sd0) begin
						lvl_q <= lvl_nxt;
					end else begin
						score_q <= '0;
						hit_q   <= 1'b0;
						lvl_q   <= (lvl_nxt < 3'sd0) ? -3'sd1 : 3'sd0;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						score_q <= scan_score;
						hit_q   <= scan_hit;
					end
				end
				ST_PRS: begin
					if (!hit_q)
						hit_q <= spike;
				end
				ST_FIN: begin
					if (ah_q == 8'd0) begin
						if (hit_q) begin
							ah_q      <= HOLD_LIM;
							auto_ev_q <= 1'b1;
							if (mh_q == 8'd0)
								count_q <= count_inc;
						end
					end else if (hit_q && ah_q > HOLD_NEAR) begin
						ah_q <= HOLD_LIM;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign movement_count = out_count_q;
	assign auto_score     = out_score_q;
	assign manual_event   = out_man_q;
	assign auto_event     = out_auto_q;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fetal_movement_detector_core: a behavioral predictor
// computes count, score and event flags per sample request; a monitor checks
// every result in order. Bursty sender, patterned receiver stalls, config
// phases across channel, count and demo settings.
// ----------------------------------------------------------------------------
module tb import fmd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN   = 50;
	localparam int HLIM  = 20;
	localparam int LIMIT = 4000000;

	typedef struct packed {
		logic [7:0] r1;
		logic [7:0] r2;
		logic [7:0] pr;
		logic       press;
	} sample_t;

	typedef struct packed {
		logic [6:0] cnt;
		logic [5:0] score;
		logic       man;
		logic       aut;
	} verdict_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [7:0] rate_one = 0, rate_two = 0;
	logic signed [7:0] pressure = 0;
	logic manual_press = 0;
	logic out_valid, out_stall = 0;
	logic [6:0] movement_count;
	logic [5:0] auto_score;
	logic manual_event, auto_event;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = 0;
	logic cfg_data = 0;

	fetal_movement_detector_core uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// predictor state
	logic [7:0] w1 [WIN];
	logic [7:0] w2 [WIN];
	logic signed [7:0] pw [16];
	int wpos, ppos, vlev, mhold, ahold, cnt, score;
	logic sel_ch, man_only, demo;

	sample_t pending_q[$];
	verdict_t verdict_q[$];
	int errors = 0;
	int cycles = 0;
	int burst = 0, gap = 0, hold_off = 0, stall_cnt = 0;
	bit pause_send = 0;
	bit hold_req = 0, hold_done = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic void bump();
		cnt++;
		if (cnt > 99) cnt = 99;
	endfunction

	function automatic bit detect_movement(sample_t s);
		int sel, sum, base, v, d, pb, a, b;
		bit hit;
		hit = 0;
		sum = 0;
		sel = sel_ch ? s.r2 : s.r1;
		if (sel < 60 || sel > 210) vlev--;
		else vlev = 2;
		if (vlev < 1) begin
			score = 0;
			if (vlev < 0) begin
				vlev = -1;
				return 0;
			end
			for (int i = 0; i < WIN; i++) begin
				w1[i] = 0;
				w2[i] = 0;
			end
			for (int i = 0; i < 16; i++) pw[i] = 0;
			wpos = 0;
			ppos = 0;
			return 0;
		end
		w1[wpos] = s.r1;
		w2[wpos] = s.r2;
		pw[ppos] = s.pr;
		wpos++;
		if (wpos >= WIN) wpos = 0;
		ppos = (ppos + 1) & 15;
		base = sel_ch ? w2[(wpos + 1) % WIN] : w1[(wpos + 1) % WIN];
		for (int i = 0; i < WIN; i++) begin
			v = sel_ch ? w2[i] : w1[i];
			d = v - base;
			if (d < 0) d = -d;
			if (base > 100 && v > base && v < base + 20 + i && d < 8) sum += v - base;
		end
		sum &= 16'hFFFF;
		if (sum > 740) hit = 1;
		score = (sum >> 6) % 40;
		if (!hit) begin
			pb = (ppos + 1) & 15;
			if (pw[pb] > 20 && int'(pw[(pb + 3) & 15]) - int'(pw[pb]) > 12)
				for (int i = 3; i < 14; i++) begin
					a = pw[(pb + i) & 15];
					b = pw[(pb + i + 2) & 15];
					if (a - b > 20 - i) hit = 1;
				end
		end
		return hit;
	endfunction

	function automatic verdict_t predict_sample(sample_t s);
		verdict_t r;
		bit afm;
		r.man = 0;
		r.aut = 0;
		if (demo) begin
			mhold = 5;
			ahold = 10;
		end else begin
			if (mhold > 0) mhold--;
			if (mhold == 0) begin
				if (s.press) begin
					mhold = HLIM;
					if (man_only || ahold == 0) bump();
					r.man = 1;
				end
			end else if (s.press && HLIM - 3 < mhold) mhold = HLIM;
			if (!man_only) begin
				if (ahold > 0) ahold--;
				afm = detect_movement(s);
				if (ahold == 0) begin
					if (afm) begin
						ahold = HLIM;
						if (mhold == 0) bump();
						r.aut = 1;
					end
				end else if (afm && HLIM - 3 < ahold) ahold = HLIM;
			end
		end
		r.cnt = cnt[6:0];
		r.score = score[5:0];
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			verdict_q.push_back(predict_sample(
				{rate_one, rate_two, pressure, manual_press}));
			void'(pending_q.pop_front());
		end
		if (in_valid && in_stall) begin
		end else if (pending_q.size() > 0 && !pause_send && burst > 0) begin
			in_valid <= 1;
			{rate_one, rate_two, pressure, manual_press} <= pending_q[0];
			burst <= burst - 1;
		end else begin
			in_valid <= 0;
			if (gap > 0) gap <= gap - 1;
			else begin
				burst <= $urandom_range(1, 30);
				gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		stall_cnt <= stall_cnt + 1;
		if (hold_req && !hold_done) begin
			hold_done <= 1;
			hold_off <= 3000;
			out_stall <= 1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else if (stall_cnt[10:8] == 3'd5)
			out_stall <= 0;
		else
			out_stall <= ($urandom_range(0, 3) == 0);
	end

	// monitor
	always @(posedge clk) begin
		verdict_t w;
		if (out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				w = verdict_q.pop_front();
				if (movement_count !== w.cnt) report("movement_count", movement_count, w.cnt);
				if (auto_score !== w.score) report("auto_score", auto_score, w.score);
				if (manual_event !== w.man) report("manual_event", manual_event, w.man);
				if (auto_event !== w.aut) report("auto_event", auto_event, w.aut);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout");
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic drain();
		wait (pending_q.size() == 0 && !in_valid);
		wait (verdict_q.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			CFG_CHANNEL: sel_ch = val;
			CFG_COUNT: man_only = val;
			CFG_DEMO: demo = val;
			default: ;
		endcase
	endtask

	function automatic sample_t rand_sample(bit structured);
		sample_t s;
		s.r1 = $urandom;
		s.r2 = $urandom;
		s.pr = $urandom;
		s.press = ($urandom_range(0, 5) == 0);
		if (structured) begin
			s.r1 = $urandom_range(0, 9) == 0 ? $urandom : 8'($urandom_range(101, 140));
			s.r2 = $urandom_range(0, 9) == 0 ? $urandom : 8'($urandom_range(101, 140));
			s.pr = $urandom_range(0, 1) ? 8'($urandom_range(15, 60)) : 8'($urandom_range(0, 30));
		end
		return s;
	endfunction

	task automatic ramp_run(input int n);
		sample_t s;
		int b;
		b = $urandom_range(101, 130);
		for (int i = 0; i < n; i++) begin
			s = rand_sample(1);
			if ($urandom_range(0, 2) != 0) begin
				s.r1 = 8'(b + $urandom_range(1, 7));
				s.r2 = 8'(b + $urandom_range(1, 7));
			end
			if ($urandom_range(0, 40) == 0) s.r1 = 8'($urandom_range(0, 59));
			pending_q.push_back(s);
		end
	endtask

	initial begin
		logic [1:0] idx;
		for (int i = 0; i < WIN; i++) begin
			w1[i] = 0;
			w2[i] = 0;
		end
		for (int i = 0; i < 16; i++) pw[i] = 0;
		pw[0] = -1;
		wpos = 0; ppos = 0; vlev = 3; mhold = 5; ahold = 10; cnt = 0; score = 0;
		sel_ch = 0; man_only = 0; demo = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed edges
		pending_q.push_back({8'd0, 8'd255, 8'h80, 1'b1});
		pending_q.push_back({8'd255, 8'd0, 8'h7F, 1'b0});
		pending_q.push_back({8'd59, 8'd211, 8'h00, 1'b1});
		pending_q.push_back({8'd60, 8'd210, 8'hFF, 1'b0});
		pending_q.push_back({8'd210, 8'd60, 8'd21, 1'b1});
		pending_q.push_back({8'd211, 8'd59, 8'd40, 1'b1});
		pending_q.push_back({8'd10, 8'd10, 8'd0, 1'b0});
		pending_q.push_back({8'd10, 8'd10, 8'd0, 1'b0});
		pending_q.push_back({8'd10, 8'd10, 8'd0, 1'b1});
		for (int i = 0; i < 12; i++)
			pending_q.push_back({8'(101 + i % 7), 8'(120 + i % 5), 8'(i < 4 ? 25 : 60 - 4 * i), 1'b0});
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			write_reg(CFG_CHANNEL, ph[0]);
			write_reg(CFG_COUNT, (ph % 5) == 3);
			write_reg(CFG_DEMO, (ph % 6) == 4);
			if (ph == 2) begin
				idx = 2'd3;
				write_reg(idx, 1'b1);
			end
			if (ph == 3) hold_req = 1;
			for (int k = 0; k < 4; k++) begin
				ramp_run($urandom_range(15, 35));
				for (int j = 0; j < 3; j++) pending_q.push_back(rand_sample(0));
			end
			if (ph == 6) begin
				wait (pending_q.size() < 40);
				pause_send = 1;
				wait (!in_valid && verdict_q.size() == 0);
				pause_send = 0;
			end
			drain();
		end
		write_reg(CFG_DEMO, 1'b0);
		write_reg(CFG_COUNT, 1'b0);
		write_reg(CFG_CHANNEL, 1'b0);
		ramp_run(20);
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/core/fmd_pkg.sv
rtl/core/fmd_rate_scan.sv
rtl/core/fmd_press_chk.sv
rtl/core/fetal_movement_detector_core.sv
tb/tb.sv
